### hw/rtl/kmpl_pkg.sv
// Shared constants and types for the pattern search block with line counting.
// Used by the match cell, the cell row and the top level; depends on nothing.

package kmpl_pkg;

    // Pattern capacity; one match cell per stored pattern byte.
    localparam int MAX_PATTERN = 64;
    localparam int CELL_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PROG_W      = $clog2(MAX_PATTERN + 1);

    // Fixed field widths of the request and result items.
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 6;
    localparam int BYTE_W = 8;
    localparam int WORD_W = 32;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_TEXT  = 2'd2;

    // Register index taken from the word address.
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    // Control broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic              clear;     // drop all partial matches
        logic              shift;     // move partial matches one cell along
        logic              flush;     // progress has reached the length: restart
        logic [BYTE_W-1:0] data_byte; // text byte to compare, or pattern byte to store
        logic              wr_en;     // store data_byte into one cell
        logic [CELL_W-1:0] wr_idx;    // cell that takes the pattern byte
    } t_row_ctrl;

endpackage

### hw/rtl/kmpl_cell.sv
// One match cell: holds one pattern byte and the flag that the pattern prefix
// ending at this byte is a suffix of the text seen so far. Uses kmpl_pkg.

module kmpl_cell import kmpl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CELL_W-1:0] i_cell_idx,
    input  t_row_ctrl         i_ctrl,
    input  logic              i_prev_hit,
    output logic              o_next_hit,
    output logic              o_hit,
    output logic [BYTE_W-1:0] o_pat
);

    logic              r_hit;
    logic [BYTE_W-1:0] r_pat;

    // The prefix grows by one byte when the neighbour matched and this byte agrees.
    assign o_next_hit = i_prev_hit && (i_ctrl.data_byte == r_pat);

    // Partial match flag; a clear wins over a shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_hit <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_hit <= o_next_hit;
        end
    end

    // Pattern byte, written only by its own index.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en && (i_ctrl.wr_idx == i_cell_idx)) begin
            r_pat <= i_ctrl.data_byte;
        end
    end

    assign o_hit = r_hit;
    assign o_pat = r_pat;

endmodule

### hw/rtl/kmpl_row.sv
// Row of match cells chained through their partial match flags, with the
// progress encoder and the pattern read-out. Uses kmpl_pkg and kmpl_cell.

module kmpl_row import kmpl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row_ctrl         i_ctrl,
    input  logic [CELL_W-1:0] i_rd_idx,
    input  logic [CELL_W-1:0] i_tap_idx,
    output logic [BYTE_W-1:0] o_rd_byte,
    output logic              o_tap_next,
    output logic [PROG_W-1:0] o_prog
);

    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN-1:0] w_prev;
    logic [MAX_PATTERN-1:0] w_next;
    logic [BYTE_W-1:0]      w_pat [MAX_PATTERN];

    // The empty prefix always matches; a flush leaves only that one.
    always_comb begin
        w_prev[0] = 1'b1;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            w_prev[k] = w_hit[k-1] && !i_ctrl.flush;
        end
    end

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        kmpl_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (CELL_W'(g)),
            .i_ctrl     (i_ctrl),
            .i_prev_hit (w_prev[g]),
            .o_next_hit (w_next[g]),
            .o_hit      (w_hit[g]),
            .o_pat      (w_pat[g])
        );
    end

    // Match progress is the longest prefix still alive.
    always_comb begin
        o_prog = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (w_hit[k]) begin
                o_prog = PROG_W'(k + 1);
            end
        end
    end

    // Completion tap at the last byte in use, and pattern read-out for replay.
    assign o_tap_next = w_next[i_tap_idx];
    assign o_rd_byte  = w_pat[i_rd_idx];

endmodule

### hw/rtl/kmp_pattern_search_with_line_count.sv
// Top level of the first-occurrence pattern search with line counting:
// stream ports, register port, counters and replay control. Uses kmpl_pkg, kmpl_row.
//
//  Channel   Direction  Transfer condition              Contents
//  s_*       in         s_tvalid & s_tready             cmd, index, byte, start line, last
//  m_*       out        m_tvalid & m_tready             found, offset, line, done
//  APB       in/out     psel & penable & pwrite         pattern_length where paddr[2] is 0
//
// A request's result is registered at the clock edge that takes the request.
// A pattern write while a partial match is held replays the held prefix through
// the cell row, one byte a cycle: the input stalls until the whole prefix has
// been replayed. Synchronous reset clears the counters and partial matches;
// the pattern bytes stay undefined until written.
// The input is held off only by that replay or by a result that is not taken.

module kmp_pattern_search_with_line_count import kmpl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,  // pattern_index[5:0], data_byte[13:6],
                                        // start_line[45:14], zero[47:46]
    input  logic [1:0]        s_tuser,  // cmd[1:0]
    input  logic              s_tlast,  // last_text
    // Output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,  // match_offset[31:0], line_number[63:32],
                                        // done_res[64], zero[71:65]
    output logic              m_tuser,  // found
    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic {ST_IDLE, ST_REPLAY} t_state;

    t_state            r_state;
    logic [LEN_W-1:0]  r_len;
    logic [WORD_W-1:0] r_offset;
    logic [WORD_W-1:0] r_line;
    logic              r_finished;
    logic [CELL_W-1:0] r_cnt;
    logic [PROG_W-1:0] r_rep_len;
    logic              r_out_valid;
    logic              r_out_found;
    logic [WORD_W-1:0] r_out_offset;
    logic [WORD_W-1:0] r_out_line;
    logic              r_out_done;

    logic [WORD_W-1:0] n_line;
    logic              n_finished;

    logic [IDX_W-1:0]  w_idx;
    logic [BYTE_W-1:0] w_byte;
    logic [WORD_W-1:0] w_start;
    logic              w_accept;
    logic              w_is_write;
    logic              w_is_start;
    logic              w_is_text;
    logic [PROG_W-1:0] w_m;
    logic [PROG_W-1:0] w_prog;
    logic              w_tap_next;
    logic [BYTE_W-1:0] w_rd_byte;
    logic              w_found;
    logic [WORD_W-1:0] w_match_off;
    t_row_ctrl         w_ctrl;

    // Request field unpacking.
    assign w_idx   = s_tdata[5:0];
    assign w_byte  = s_tdata[13:6];
    assign w_start = s_tdata[45:14];

    // A new request is taken when idle and the result slot is free or draining.
    assign s_tready = (r_state == ST_IDLE) && (!r_out_valid || m_tready);
    assign w_accept = s_tvalid && s_tready;

    assign w_is_write = w_accept && (s_tuser == CMD_WRITE)
                        && (32'(w_idx) < MAX_PATTERN);
    assign w_is_start = w_accept && (s_tuser == CMD_START);
    assign w_is_text  = w_accept && (s_tuser == CMD_TEXT) && !r_finished;

    // Length in use, held between one and the capacity.
    always_comb begin
        if (r_len == '0) begin
            w_m = PROG_W'(1);
        end else if (32'(r_len) > MAX_PATTERN) begin
            w_m = PROG_W'(MAX_PATTERN);
        end else begin
            w_m = PROG_W'(r_len);
        end
    end

    // Cell row control.
    always_comb begin
        w_ctrl.flush     = w_is_text && (w_prog >= w_m);
        w_ctrl.shift     = w_is_text || (r_state == ST_REPLAY);
        w_ctrl.clear     = w_is_start || (w_is_text && w_found)
                           || (w_is_write && (w_prog != '0));
        w_ctrl.data_byte = (r_state == ST_REPLAY) ? w_rd_byte : w_byte;
        w_ctrl.wr_en     = w_is_write;
        w_ctrl.wr_idx    = CELL_W'(w_idx);
    end

    kmpl_row u_row (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_rd_idx   (r_cnt),
        .i_tap_idx  (CELL_W'(w_m - PROG_W'(1))),
        .o_rd_byte  (w_rd_byte),
        .o_tap_next (w_tap_next),
        .o_prog     (w_prog)
    );

    // A completed pattern reports the offset of its first byte.
    assign w_found     = w_is_text && w_tap_next;
    assign w_match_off = r_offset - WORD_W'(w_m) + WORD_W'(1);

    // Next line count and finish flag, shared by the counters and the result.
    always_comb begin
        if (w_is_start) begin
            n_line = w_start;
        end else if (w_is_text && (w_byte == NEWLINE_BYTE)) begin
            n_line = r_line + WORD_W'(1);
        end else begin
            n_line = r_line;
        end
        if (w_is_start) begin
            n_finished = 1'b0;
        end else if (w_is_text) begin
            n_finished = w_found || s_tlast;
        end else begin
            n_finished = r_finished;
        end
    end

    // Search counters and the length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= LEN_W'(1);
            r_offset   <= '0;
            r_line     <= '0;
            r_finished <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready
                && (paddr[2] == REG_PATTERN_LENGTH)) begin
                r_len <= pwdata[LEN_W-1:0];
            end
            if (w_is_start) begin
                r_offset <= '0;
            end else if (w_is_text) begin
                r_offset <= r_offset + WORD_W'(1);
            end
            r_line     <= n_line;
            r_finished <= n_finished;
        end
    end

    // Replay sequencer and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_rep_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_is_write && (w_prog != '0)) begin
                        r_state   <= ST_REPLAY;
                        r_cnt     <= '0;
                        r_rep_len <= w_prog;
                    end
                end
                ST_REPLAY: begin
                    r_cnt <= r_cnt + CELL_W'(1);
                    if (PROG_W'(r_cnt) + PROG_W'(1) == r_rep_len) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (w_accept) begin
                r_out_valid  <= 1'b1;
                r_out_found  <= w_found;
                r_out_offset <= w_found ? w_match_off : '0;
                r_out_line   <= n_line;
                r_out_done   <= n_finished;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result stream.
    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out_found;
    assign m_tdata  = {7'b0, r_out_done, r_out_line, r_out_offset};

    // Register read-back; pready is always high, so writes complete with no wait states.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ? {25'b0, r_len} : 32'b0;

endmodule
